// ===== rtl/nhbf_pkg.sv =====
package nhbf_pkg;

  // Hash and filter geometry.
  localparam int unsigned HashW      = 64;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned HashBytes  = HashW / ByteW;
  localparam int unsigned FilterBits = 256;
  localparam int unsigned FilterIdxW = $clog2(FilterBits);

  localparam logic [HashW-1:0] HashSeed = HashW'(5381);
  localparam logic [ByteW-1:0] Colon    = 8'h3A;

  // A finished name on its way to the filter stage.
  typedef struct packed {
    logic             insert;
    logic [HashW-1:0] hash;
  } fold_req_t;

  // One hash step: h * 33 xor the sign-extended byte.
  function automatic logic [HashW-1:0] hash_byte(input logic [HashW-1:0] h,
                                                 input logic [ByteW-1:0] b);
    logic [HashW-1:0] ext;
    ext = {{(HashW - ByteW){b[ByteW-1]}}, b};
    return ((h << 5) + h) ^ ext;
  endfunction

  // Sum of the eight hash bytes, modulo 256.
  function automatic logic [ByteW-1:0] fold_hash(input logic [HashW-1:0] h);
    logic [ByteW-1:0] sum;
    sum = '0;
    for (int k = 0; k < HashBytes; k++) begin
      sum = sum + h[k*ByteW +: ByteW];
    end
    return sum;
  endfunction

endpackage

// ===== rtl/nhbf_hasher.sv =====
module nhbf_hasher (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       command_i,
  input  logic [nhbf_pkg::ByteW-1:0] name_byte_i,
  input  logic                       last_i,
  output logic [nhbf_pkg::HashW-1:0] hash_next_o
);

  logic [nhbf_pkg::HashW-1:0] hash_q, hash_d;
  logic                       prev_colon_q, prev_colon_d;
  logic                       sep_seen_q, sep_seen_d;
  logic                       is_colon;
  logic                       restart;

  assign is_colon = (name_byte_i == nhbf_pkg::Colon);
  // Only an insert restarts on its first double colon.
  assign restart  = command_i && !sep_seen_q && prev_colon_q && is_colon;

  assign hash_next_o = restart ? nhbf_pkg::HashSeed
                               : nhbf_pkg::hash_byte(hash_q, name_byte_i);

  always_comb begin
    hash_d       = hash_q;
    prev_colon_d = prev_colon_q;
    sep_seen_d   = sep_seen_q;
    if (accept_i) begin
      if (last_i) begin
        hash_d       = nhbf_pkg::HashSeed;
        prev_colon_d = 1'b0;
        sep_seen_d   = 1'b0;
      end else begin
        hash_d       = hash_next_o;
        prev_colon_d = is_colon;
        sep_seen_d   = sep_seen_q || restart;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q       <= nhbf_pkg::HashSeed;
      prev_colon_q <= 1'b0;
      sep_seen_q   <= 1'b0;
    end else begin
      hash_q       <= hash_d;
      prev_colon_q <= prev_colon_d;
      sep_seen_q   <= sep_seen_d;
    end
  end

endmodule

// ===== rtl/nhbf_filter.sv =====
module nhbf_filter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       advance_i,
  input  nhbf_pkg::fold_req_t        req_i,
  output logic [nhbf_pkg::ByteW-1:0] hash_value_o,
  output logic                       hit_o
);

  logic [nhbf_pkg::FilterBits-1:0] bits_q, bits_d;
  logic [nhbf_pkg::FilterIdxW-1:0] idx;

  assign hash_value_o = nhbf_pkg::fold_hash(req_i.hash);
  assign idx          = hash_value_o[nhbf_pkg::FilterIdxW-1:0];
  assign hit_o        = !req_i.insert && bits_q[idx];

  always_comb begin
    bits_d = bits_q;
    if (advance_i && req_i.insert) begin
      bits_d[idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
    end else begin
      bits_q <= bits_d;
    end
  end

endmodule

// ===== rtl/name_hash_bitmap_filter.sv =====
// A name's hash is registered in the fold stage, then its result in the output register.
// Throughput: one name byte per cycle unless stalled; the hash register updates once per
// accepted byte. The output register decouples the two sides, so input stalls only when
// both the fold stage and the output register hold results that have not been taken.
// Reset (rst_ni low, asynchronous) clears the filter bitmap, the colon flags and all valid
// bits, and loads the running hash with its seed of 5381.
module name_hash_bitmap_filter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       command_i,
  input  logic [nhbf_pkg::ByteW-1:0] name_byte_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [nhbf_pkg::ByteW-1:0] hash_value_o,
  output logic                       hit_o,
  output logic                       inserted_o
);

  logic                       in_acc;
  logic                       s2_adv;
  logic [nhbf_pkg::HashW-1:0] hash_next;

  // Fold stage: holds the full hash of a finished name.
  logic                       s1_valid_q, s1_valid_d;
  nhbf_pkg::fold_req_t        s1_q;

  // Output register.
  logic                       out_valid_q, out_valid_d;
  logic [nhbf_pkg::ByteW-1:0] hash_value_q;
  logic                       hit_q, inserted_q;

  logic [nhbf_pkg::ByteW-1:0] fold_value;
  logic                       fold_hit;

  // The fold stage moves forward whenever the output register is empty or being drained.
  assign s2_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // The running hash and the separator tracking live in the hasher.
  nhbf_hasher u_hasher (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .command_i   (command_i),
    .name_byte_i (name_byte_i),
    .last_i      (last_i),
    .hash_next_o (hash_next)
  );

  // Folding and the bitmap lookup/update happen in one step, in request order, so an
  // insert is always visible to every later query.
  nhbf_filter u_filter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (s2_adv),
    .req_i        (s1_q),
    .hash_value_o (fold_value),
    .hit_o        (fold_hit)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc && last_i) begin
      s1_valid_d = 1'b1;
    end else if (s2_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s2_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc && last_i) begin
      s1_q.insert <= command_i;
      s1_q.hash   <= hash_next;
    end
    if (s2_adv) begin
      hash_value_q <= fold_value;
      hit_q        <= fold_hit;
      inserted_q   <= s1_q.insert;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_value_q;
  assign hit_o        = hit_q;
  assign inserted_o   = inserted_q;

endmodule

// ===== rtl/nhbf_checker.sv =====
module nhbf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       command_i,
  input logic [nhbf_pkg::ByteW-1:0] name_byte_i,
  input logic                       last_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [nhbf_pkg::ByteW-1:0] hash_value_o,
  input logic                       hit_o,
  input logic                       inserted_o
);

  // A waiting request keeps its payload until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(command_i)
                                  && $stable(name_byte_i) && $stable(last_i))
    else $error("request changed while stalled");

  // A pending result must stay until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(hash_value_o) && $stable(hit_o)
                                    && $stable(inserted_o))
    else $error("result payload changed while stalled");

  // An insert never reports a hit.
  a_insert_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && inserted_o |-> !hit_o)
    else $error("insert result reports a hit");

  // Input stalls only when a result is waiting and the sink is not taking it.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

endmodule

bind name_hash_bitmap_filter nhbf_checker u_nhbf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .command_i    (command_i),
  .name_byte_i  (name_byte_i),
  .last_i       (last_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .hash_value_o (hash_value_o),
  .hit_o        (hit_o),
  .inserted_o   (inserted_o)
);
